// File: rtl/core/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg
// Types, constants and codes shared by the running statistics block.
// ----------------------------------------------------------------------------
package rmvs_pkg;

   localparam int COUNT_BITS = 24;
   localparam int FRAC_BITS  = 16;
   localparam int MEAN_EXT   = 16;
   localparam int MEAN_BITS  = 48;
   localparam int SAMPLE_BITS = 32;
   localparam int Q_BITS     = 64;
   localparam int DIV_BITS   = 64;
   localparam int DCNT_BITS  = $clog2(DIV_BITS + 1);

   localparam logic [0:0] CSR_MISSING_VALUE = 1'b0;
   localparam logic [0:0] CSR_SKIP_MISSING  = 1'b1;

   typedef struct packed {
      logic signed [31:0] sample;
      logic               is_last;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] mean;
      logic [30:0]        mean_mag;
      logic [62:0]        variance;
      logic [30:0]        std_dev;
      logic [23:0]        sample_count;
      logic               var_valid;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_TERM_DIV,
      ST_MEAN_DIV,
      ST_ABS_DIV,
      ST_UPDATE,
      ST_VAR_DIV,
      ST_SQRT_INIT,
      ST_SQRT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DIV_BITS-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
      logic [DIV_BITS-1:0] remainder;
   } div_rsp_type;

endpackage

// File: rtl/core/running_mean_variance_stats.sv
// A skipped word or the first sample of a set needs no division of its own; a
// later sample takes three divisions (term, mean and mean absolute value); a
// word that closes a set of two or more samples adds a variance division and a
// 32-step root.
// One word is in work at a time; the shared bit-serial divider sets the rate.
// Reset (synchronous) clears state, statistics, CSR settings and the result valid flag.
// ----------------------------------------------------------------------------
// running_mean_variance_stats
// Welford running mean, mean absolute value, variance and deviation.
// ----------------------------------------------------------------------------
module running_mean_variance_stats
   import rmvs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic signed [31:0]          missing_ff;
   logic                        skip_ff;
   logic [COUNT_BITS-1:0]       cnt_ff, cnt_in;
   logic signed [MEAN_BITS-1:0] mean_ff, mean_in;
   logic [MEAN_BITS-1:0]        amean_ff, amean_in;
   logic [Q_BITS-1:0]           q_ff, q_in;
   logic signed [31:0]          smp_ff;
   logic                        last_ff;
   logic [31:0]                 ad_ff;
   logic [63:0]                 term_ff;
   logic                        mneg_ff, aneg_ff;
   logic [63:0]                 mquo_ff, aquo_ff;
   logic [62:0]                 var_ff;
   logic [63:0]                 sq_v_ff, sq_r_ff, sq_b_ff;
   logic                        rsp_valid_ff;
   rsp_word_type                rsp_ff;

   div_cmd_type div_cmd;
   div_rsp_type div_rsp;

   logic                        accept_w, take;
   logic [COUNT_BITS-1:0]       cnt_new;
   logic signed [32:0]          abs_s;
   logic signed [33:0]          d_w;
   logic [31:0]                 ad_w;
   logic [63:0]                 d2_w;
   logic signed [MEAN_BITS:0]   xm, xa, mdiff, adiff;
   logic [63:0]                 mmag, amag;
   logic [63:0]                 term_w;
   logic [64:0]                 qsum;
   logic [64:0]                 sq_t;
   logic signed [31:0]          mfloor;
   logic signed [32:0]          afloor;

   rmvs_divider u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .rsp(div_rsp));

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign take      = req_valid && req_ready;
   assign accept_w  = !(skip_ff && (req_data.sample == missing_ff));
   assign cnt_new   = (&cnt_ff) ? cnt_ff : cnt_ff + 1'b1;
   assign abs_s     = req_data.sample[31] ? -33'(req_data.sample) : 33'(req_data.sample);
   assign mfloor    = 32'(mean_ff >>> MEAN_EXT);
   assign afloor    = 33'(amean_ff >>> MEAN_EXT);
   assign d_w       = 34'(req_data.sample) - 34'(mfloor);
   assign ad_w      = 32'(d_w[33] ? -d_w : d_w);
   assign d2_w      = ad_ff * ad_ff;
   assign xm        = {smp_ff[31], smp_ff, 16'b0};
   assign xa        = {(smp_ff[31] ? -33'(smp_ff) : 33'(smp_ff)), 16'b0};
   assign mdiff     = xm - 49'(mean_ff);
   assign adiff     = xa - 49'(amean_ff);
   assign mmag      = 64'(mdiff[MEAN_BITS] ? -mdiff : mdiff);
   assign amag      = 64'(adiff[MEAN_BITS] ? -adiff : adiff);
   assign term_w    = d2_w - div_rsp.quotient
                      - 64'(div_rsp.remainder != '0);
   assign qsum      = {1'b0, q_ff} + {1'b0, term_ff};
   assign sq_t      = {1'b0, sq_v_ff} - ({1'b0, sq_r_ff} + {1'b0, sq_b_ff});

   always_comb begin
      state_in = state_ff;
      div_cmd  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (accept_w && cnt_new != COUNT_BITS'(1)) begin
                  state_in = ST_SQUARE;
               end else if (req_data.is_last) begin
                  state_in = (!accept_w && cnt_ff >= COUNT_BITS'(2)) ? ST_VAR_DIV
                                                                     : ST_EMIT;
               end
            end
         end
         ST_SQUARE: begin
            state_in = ST_TERM_DIV;
            div_cmd.start    = 1'b1;
            div_cmd.dividend = d2_w;
            div_cmd.divisor  = 64'(cnt_ff);
         end
         ST_TERM_DIV: if (div_rsp.done) begin
            state_in = ST_MEAN_DIV;
            div_cmd.start = 1'b1;
            div_cmd.dividend = mmag;
            div_cmd.divisor  = 64'(cnt_ff);
         end
         ST_MEAN_DIV: if (div_rsp.done) begin
            state_in = ST_ABS_DIV;
            div_cmd.start = 1'b1;
            div_cmd.dividend = amag;
            div_cmd.divisor  = 64'(cnt_ff);
         end
         ST_ABS_DIV: if (div_rsp.done) state_in = ST_UPDATE;
         ST_UPDATE: state_in = !last_ff ? ST_IDLE :
                               (cnt_ff >= COUNT_BITS'(2)) ? ST_VAR_DIV : ST_EMIT;
         ST_VAR_DIV: begin
            state_in = ST_SQRT_INIT;
         end
         ST_SQRT_INIT: if (div_rsp.done) state_in = ST_SQRT;
         ST_SQRT: if (sq_b_ff == '0) state_in = ST_EMIT;
         ST_EMIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_VAR_DIV) begin
         div_cmd.start    = 1'b1;
         div_cmd.dividend = q_ff;
         div_cmd.divisor  = 64'(cnt_ff - 1'b1);
      end
   end

   always_comb begin
      cnt_in   = cnt_ff;
      mean_in  = mean_ff;
      amean_in = amean_ff;
      q_in     = q_ff;
      if (state_ff == ST_IDLE && take && accept_w) begin
         cnt_in = cnt_new;
         if (cnt_new == COUNT_BITS'(1)) begin
            mean_in  = {req_data.sample, 16'b0};
            amean_in = 48'({abs_s, 16'b0});
            q_in     = '0;
         end
      end
      if (state_ff == ST_UPDATE) begin
         q_in     = qsum[64] ? '1 : qsum[63:0];
         mean_in  = mean_ff + (mneg_ff ? -48'(mquo_ff) : 48'(mquo_ff));
         amean_in = amean_ff + (aneg_ff ? -48'(aquo_ff) : 48'(aquo_ff));
      end
      if (state_ff == ST_EMIT) begin
         cnt_in = '0; mean_in = '0; amean_in = '0; q_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         missing_ff   <= '0;
         skip_ff      <= 1'b0;
         cnt_ff       <= '0;
         mean_ff      <= '0;
         amean_ff     <= '0;
         q_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         mean_ff  <= mean_in;
         amean_ff <= amean_in;
         q_ff     <= q_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MISSING_VALUE: missing_ff <= csr_wdata;
               CSR_SKIP_MISSING:  skip_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
         if (state_ff == ST_EMIT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)     rsp_valid_ff <= 1'b0;
      end
      if (take) begin
         smp_ff  <= req_data.sample;
         last_ff <= req_data.is_last;
         ad_ff   <= ad_w;
      end
      if (state_ff == ST_TERM_DIV && div_rsp.done) begin
         term_ff <= term_w;
         mneg_ff <= mdiff[MEAN_BITS];
         aneg_ff <= adiff[MEAN_BITS];
      end
      if (state_ff == ST_MEAN_DIV && div_rsp.done) mquo_ff <= div_rsp.quotient;
      if (state_ff == ST_ABS_DIV && div_rsp.done)  aquo_ff <= div_rsp.quotient;
      if (state_ff == ST_SQRT_INIT && div_rsp.done) begin
         var_ff  <= div_rsp.quotient[63] ? '1 : div_rsp.quotient[62:0];
         sq_v_ff <= div_rsp.quotient[63] ? {1'b0, 63'h7FFFFFFFFFFFFFFF}
                                         : div_rsp.quotient;
         sq_r_ff <= '0;
         sq_b_ff <= 64'h4000000000000000;
      end
      if (state_ff == ST_SQRT && sq_b_ff != '0) begin
         if (!sq_t[64]) begin
            sq_v_ff <= sq_t[63:0];
            sq_r_ff <= (sq_r_ff >> 1) + sq_b_ff;
         end else begin
            sq_r_ff <= sq_r_ff >> 1;
         end
         sq_b_ff <= sq_b_ff >> 2;
      end
      if (state_ff == ST_EMIT) begin
         rsp_ff.mean         <= mfloor;
         rsp_ff.mean_mag     <= afloor[32] ? '0 : (afloor[31] ? '1 : afloor[30:0]);
         rsp_ff.sample_count <= 24'(cnt_ff);
         rsp_ff.var_valid    <= cnt_ff >= COUNT_BITS'(2);
         rsp_ff.variance     <= (cnt_ff >= COUNT_BITS'(2)) ? var_ff : '0;
         rsp_ff.std_dev      <= (cnt_ff < COUNT_BITS'(2)) ? '0 :
                                (|sq_r_ff[63:31]) ? '1 : sq_r_ff[30:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/core/rmvs_divider.sv
// ----------------------------------------------------------------------------
// rmvs_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmvs_divider
   import rmvs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_rsp_type rsp
);

   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [DIV_BITS-1:0]  dvs_ff, dvs_in;
   logic [DCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_BITS:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIV_BITS-1]} - {1'b0, dvs_ff};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = DCNT_BITS'(DIV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DIV_BITS]) begin
            rem_in = trial[DIV_BITS-1:0];
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DIV_BITS-2:0], quo_ff[DIV_BITS-1]};
            quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// File: rtl/core/rmvs_checker.sv
// ----------------------------------------------------------------------------
// rmvs_checker
// Port-level checks of the running statistics block.
// ----------------------------------------------------------------------------
module rmvs_checker
   import rmvs_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_no_take_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

   a_valid_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.var_valid |-> rsp_data.variance == '0)
      else $error("variance without two samples");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid || !req_ready)
      else $error("ready during result");

endmodule

bind running_mean_variance_stats rmvs_checker u_rmvs_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
